// File: hw/rtl/cfm_pkg.sv
// ----------------------------------------------------------------------------
// cfm_pkg: shared types and constants of the channel fold mixer
// Channel counts, word widths, the divider handshake structs and helpers.
// ----------------------------------------------------------------------------
package cfm_pkg;

   localparam int MAX_CH   = 16;
   localparam int CH_W     = (MAX_CH > 1) ? $clog2(MAX_CH) : 1;
   localparam int CNT_W    = $clog2(MAX_CH + 1);
   localparam int SAMPLE_W = 24;
   localparam int ACC_W    = SAMPLE_W + CNT_W - 1;
   localparam int DIV_CNT_W = $clog2(ACC_W);
   localparam int REG_W    = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_IN_CHANNELS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_CHANNELS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMALIZE    = 2'd2;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   typedef struct packed {
      logic             start;
      logic [ACC_W-1:0] dividend;
      logic [CNT_W-1:0] divisor;
   } div_ctl_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [ACC_W-1:0] quotient;
   } div_sts_type;

   // zero acts as one, anything above the channel limit acts as the limit
   function automatic logic [CNT_W-1:0] clamp_count(input logic [REG_W-1:0] v);
      logic [CNT_W-1:0] r;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (32'(v) > MAX_CH) begin
         r = CNT_W'(MAX_CH);
      end else begin
         r = CNT_W'(v);
      end
      return r;
   endfunction

   // pos mod n by restoring subtraction, one quotient bit per step
   function automatic logic [CH_W-1:0] fold_slot(input logic [CH_W-1:0] pos,
                                                 input logic [CNT_W-1:0] n);
      logic [CH_W+CNT_W-1:0] rem;
      logic [CH_W+CNT_W-1:0] sub;
      rem = (CH_W+CNT_W)'(pos);
      for (int j = CH_W - 1; j >= 0; j--) begin
         sub = (CH_W+CNT_W)'(n) << j;
         if (rem >= sub) begin
            rem = rem - sub;
         end
      end
      return rem[CH_W-1:0];
   endfunction

endpackage

// File: hw/rtl/cfm_if.sv
// ----------------------------------------------------------------------------
// cfm_if: word channels of the channel fold mixer
// Input sample channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface cfm_req_if;
   import cfm_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface cfm_rsp_if;
   import cfm_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] out_sample;
   logic [CH_W-1:0]            out_channel;
   logic                       last_of_frame;
   modport source (output valid, output out_sample, output out_channel,
                   output last_of_frame, input ready);
   modport sink   (input valid, input out_sample, input out_channel,
                   input last_of_frame, output ready);
endinterface

interface cfm_csr_if;
   import cfm_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [REG_W-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/cfm_div.sv
// ----------------------------------------------------------------------------
// cfm_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses one cycle.
// ----------------------------------------------------------------------------
module cfm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  cfm_pkg::div_ctl_type ctl,
   output cfm_pkg::div_sts_type sts
);
   import cfm_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [ACC_W-1:0]     quo_ff, quo_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]     dvs_ff, dvs_in;
   logic [CNT_W:0]       shifted;
   logic                 fits;

   assign shifted = {rem_ff, quo_ff[ACC_W-1]};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = ctl.dividend;
         rem_in  = '0;
         dvs_in  = ctl.divisor;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when the divisor fits
         if (fits) begin
            rem_in = CNT_W'(shifted - {1'b0, dvs_ff});
         end else begin
            rem_in = shifted[CNT_W-1:0];
         end
         quo_in = {quo_ff[ACC_W-2:0], fits};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(ACC_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign sts.busy     = busy_ff;
   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;

`ifndef SYNTH
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");
   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !ctl.start && cnt_ff != DIV_CNT_W'(ACC_W - 1)) |=> busy_ff)
      else $error("divider stopped early");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !ctl.start)
      else $error("divider started while busy");
`endif

endmodule

// File: hw/rtl/channel_fold_mixer.sv
// An input word is taken while idle and accumulated in the next cycle, so a
//   new input word is taken only once the last one is added; the frame's
//   closing word first derives k on the shared divider when normalize is on,
//   then each output word is read, loaded, divided one bit per cycle and sent.
// Throughput is set by the single shared 28-bit restoring divider.
// Reset (synchronous, active high): registers 1/1/0, all accumulators read as zero.
// ----------------------------------------------------------------------------
// channel_fold_mixer: modulo channel down-mix
// Folds input channel i into accumulator i mod out_channels, then emits one
// saturated word per output channel, normalized when normalize is on, at the end of each frame.
// ----------------------------------------------------------------------------
module channel_fold_mixer (
   input logic      clock,
   input logic      reset,
   cfm_req_if.sink  req_bus,
   cfm_rsp_if.source rsp_bus,
   cfm_csr_if.sink  csr_bus
);
   import cfm_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,   // wait for an input word
      ST_ADD  = 6'b000010,   // add the word into its accumulator
      ST_KDIV = 6'b000100,   // derive k = ceil(in / out)
      ST_RD   = 6'b001000,   // read the accumulator of the current channel
      ST_LOAD = 6'b010000,   // start dividing its magnitude by k
      ST_DIV  = 6'b100000    // wait for the quotient, then send
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [REG_W-1:0] in_ch_ff, in_ch_in;
   logic [REG_W-1:0] out_ch_ff, out_ch_in;
   logic             norm_ff, norm_in;
   logic [CNT_W-1:0] n_in, n_out;

   // frame tracking
   logic [CH_W-1:0]  pos_ff, pos_in;
   logic [CH_W-1:0]  slot_ff, slot_in;
   logic             last_ff, last_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [CH_W-1:0]  chan_ff, chan_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic             neg_ff, neg_in;
   logic             sending;

   // accumulator store with one registered read port; valid bits give zero
   logic signed [ACC_W-1:0] acc_mem [MAX_CH];
   logic [MAX_CH-1:0]       vld_ff, vld_in;
   logic signed [ACC_W-1:0] rd_data_ff;
   logic                    rd_vld_ff;
   logic [CH_W-1:0]         rd_addr;
   logic                    wr_en;
   logic signed [ACC_W-1:0] wr_data;
   logic signed [ACC_W-1:0] acc_val;
   logic [ACC_W-1:0]        acc_mag;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic [CH_W-1:0]            rsp_chan_ff, rsp_chan_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       rsp_free;
   logic signed [ACC_W:0]      quo_signed;
   logic                       chan_last;

   div_ctl_type div_ctl;
   div_sts_type div_sts;

   cfm_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .sts   (div_sts)
   );

   assign n_in  = clamp_count(in_ch_ff);
   assign n_out = clamp_count(out_ch_ff);

   // register writes are always taken; an unknown index is dropped
   assign csr_bus.ready = 1'b1;

   always_comb begin
      in_ch_in  = in_ch_ff;
      out_ch_in = out_ch_ff;
      norm_in   = norm_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_IN_CHANNELS:  in_ch_in  = csr_bus.data;
            CSR_OUT_CHANNELS: out_ch_in = csr_bus.data;
            CSR_NORMALIZE:    norm_in   = csr_bus.data[0];
            default:          ;
         endcase
      end
   end

   assign req_bus.ready = (state_ff == ST_IDLE);

   // read the folding slot while idle, the output channel in ST_RD
   assign rd_addr = (state_ff == ST_RD) ? chan_ff : fold_slot(pos_ff, n_out);

   assign acc_val   = rd_vld_ff ? rd_data_ff : '0;
   assign acc_mag   = acc_val[ACC_W-1] ? ACC_W'(-acc_val) : ACC_W'(acc_val);
   assign wr_data   = acc_val + ACC_W'(sample_ff);
   assign chan_last = ({1'b0, chan_ff} == CNT_W'(n_out - CNT_W'(1)));
   assign rsp_free  = !rsp_valid_ff || rsp_bus.ready;

   // apply the sign of the sum to the truncated quotient, then clip to 24 bits
   assign quo_signed = neg_ff ? -$signed({1'b0, div_sts.quotient})
                              :  $signed({1'b0, div_sts.quotient});

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      slot_in    = slot_ff;
      last_in    = last_ff;
      sample_in  = sample_ff;
      chan_in    = chan_ff;
      k_in       = k_ff;
      neg_in     = neg_ff;
      vld_in     = vld_ff;
      wr_en      = 1'b0;
      sending    = 1'b0;
      div_ctl    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               sample_in = req_bus.sample;
               slot_in   = rd_addr;
               last_in   = ({1'b0, pos_ff} + CNT_W'(1)) >= n_in;
               pos_in    = pos_ff + CH_W'(1);
               state_in  = ST_ADD;
            end
         end
         ST_ADD: begin
            wr_en           = 1'b1;
            vld_in[slot_ff] = 1'b1;
            chan_in         = '0;
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (norm_ff) begin
               // k = (in + out - 1) / out on the shared divider
               div_ctl.start    = 1'b1;
               div_ctl.dividend = ACC_W'({1'b0, n_in} + {1'b0, n_out} - (CNT_W+1)'(1));
               div_ctl.divisor  = n_out;
               state_in         = ST_KDIV;
            end else begin
               k_in     = CNT_W'(1);
               state_in = ST_RD;
            end
         end
         ST_KDIV: begin
            if (div_sts.done) begin
               k_in     = div_sts.quotient[CNT_W-1:0];
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            neg_in           = acc_val[ACC_W-1];
            div_ctl.start    = 1'b1;
            div_ctl.dividend = acc_mag;
            div_ctl.divisor  = k_ff;
            state_in         = ST_DIV;
         end
         ST_DIV: begin
            // hold the quotient until the result register frees up
            if ((div_sts.done || !div_sts.busy) && rsp_free) begin
               sending = 1'b1;
               if (chan_last) begin
                  vld_in   = '0;
                  pos_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  chan_in  = chan_ff + CH_W'(1);
                  state_in = ST_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_chan_in   = rsp_chan_ff;
      rsp_last_in   = rsp_last_ff;
      if (sending) begin
         rsp_valid_in = 1'b1;
         rsp_chan_in  = chan_ff;
         rsp_last_in  = chan_last;
         if (quo_signed > (ACC_W+1)'(SAMPLE_MAX)) begin
            rsp_sample_in = SAMPLE_MAX;
         end else if (quo_signed < (ACC_W+1)'(SAMPLE_MIN)) begin
            rsp_sample_in = SAMPLE_MIN;
         end else begin
            rsp_sample_in = quo_signed[SAMPLE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_ch_ff     <= REG_W'(1);
         out_ch_ff    <= REG_W'(1);
         norm_ff      <= 1'b0;
         pos_ff       <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_ch_ff     <= in_ch_in;
         out_ch_ff    <= out_ch_in;
         norm_ff      <= norm_in;
         pos_ff       <= pos_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      slot_ff       <= slot_in;
      last_ff       <= last_in;
      sample_ff     <= sample_in;
      chan_ff       <= chan_in;
      k_ff          <= k_in;
      neg_ff        <= neg_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_chan_ff   <= rsp_chan_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // accumulator memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         acc_mem[slot_ff] <= wr_data;
      end
      rd_data_ff <= acc_mem[rd_addr];
      rd_vld_ff  <= vld_ff[rd_addr];
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.out_sample    = rsp_sample_ff;
   assign rsp_bus.out_channel   = rsp_chan_ff;
   assign rsp_bus.last_of_frame = rsp_last_ff;

`ifndef SYNTH
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");
   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      (sending && chan_last) |=> (pos_ff == '0 && vld_ff == '0))
      else $error("frame end did not clear the accumulators");
   a_send_needs_quotient: assert property (@(posedge clock) disable iff (reset)
      sending |-> !div_sts.busy)
      else $error("result sent while division still running");
   a_last_channel: assert property (@(posedge clock) disable iff (reset)
      (sending && chan_last) |=> (rsp_bus.valid && rsp_bus.last_of_frame))
      else $error("last channel not flagged");
`endif

endmodule

// File: tb/channel_fold_mixer_test.sv
// ----------------------------------------------------------------------------
// channel_fold_mixer_test: self-checking bench for the channel fold mixer
// Drives frames of samples and register writes, and predicts every mixed
// word from a behavioral copy of the fold, scale and clip rules. Each
// received word is compared in order against the oldest prediction.
// ----------------------------------------------------------------------------
module channel_fold_mixer_test;
   import cfm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // register index outside the list; the block must ignore it
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   localparam int SETTLE_CYCLES = 40;     // quiet time before a register write
   localparam int TAIL_CYCLES   = 100;    // quiet time before the verdict
   localparam int HOLD_CYCLES   = 400;    // long receiver hold-off
   localparam int RANDOM_WORDS  = 220;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int REPORT_LIMIT  = 10;

   typedef enum logic {ROW_CSR, ROW_WORD} row_kind_type;
   typedef enum {TONE_FULL, TONE_QUIET, TONE_LOUD} tone_type;
   typedef enum {DRAIN_FREE, DRAIN_CHOPPY, DRAIN_SLOW} drain_mode_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] out_sample;
      logic [CH_W-1:0]            out_channel;
      logic                       last_of_frame;
   } mix_word_type;

   // one line of the directed plan: a register write or a sample word,
   // optionally with the mixed sample typed in by hand
   typedef struct {
      row_kind_type               kind;
      logic [CSR_IDX_W-1:0]       index;
      logic signed [SAMPLE_W-1:0] value;
      bit                         typed;
      logic signed [SAMPLE_W-1:0] want;
   } plan_row_type;

   logic clock;
   logic reset;

   cfm_req_if req_bus ();
   cfm_rsp_if rsp_bus ();
   cfm_csr_if csr_bus ();

   channel_fold_mixer u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // ---------------------------------------------------------------------
   // Behavioral copy of the mixer: registers as written, running sums and
   // the position inside the current frame.
   // ---------------------------------------------------------------------
   logic [REG_W-1:0] cfg_in_ch;
   logic [REG_W-1:0] cfg_out_ch;
   logic             cfg_norm;
   int               fold_sum [MAX_CH];
   int               frame_pos;

   mix_word_type pending_mix [$];   // predicted words not yet received
   mix_word_type head_word;

   int  fail_count;
   int  cycle_count;
   int  burst_left;
   bit  hold_off_req;
   plan_row_type plan [$];

   // zero acts as one, anything past the channel limit acts as the limit
   function automatic int span_of(input logic [REG_W-1:0] v);
      int n;
      n = int'(v);
      if (n < 1) begin
         n = 1;
      end else if (n > MAX_CH) begin
         n = MAX_CH;
      end
      return n;
   endfunction

   // fold one sample into its sum; on the closing sample of a frame queue
   // one scaled, clipped word per output channel and clear the sums
   task automatic fold_sample(input logic signed [SAMPLE_W-1:0] s);
      int           n_in;
      int           n_out;
      int           k;
      int           q;
      mix_word_type w;
      n_in  = span_of(cfg_in_ch);
      n_out = span_of(cfg_out_ch);
      fold_sum[frame_pos % n_out] += int'(s);
      frame_pos++;
      if (frame_pos >= n_in) begin
         k = cfg_norm ? (n_in + n_out - 1) / n_out : 1;
         for (int c = 0; c < n_out; c++) begin
            // integer division truncates toward zero, as the scaling must
            q = fold_sum[c] / k;
            if (q > int'(SAMPLE_MAX)) begin
               q = int'(SAMPLE_MAX);
            end else if (q < int'(SAMPLE_MIN)) begin
               q = int'(SAMPLE_MIN);
            end
            w.out_sample    = SAMPLE_W'(q);
            w.out_channel   = CH_W'(c);
            w.last_of_frame = (c == n_out - 1);
            pending_mix.push_back(w);
         end
         foreach (fold_sum[i]) fold_sum[i] = 0;
         frame_pos = 0;
      end
   endtask

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("[%0t] %s", $realtime, msg);
      end
   endtask

   // ---------------------------------------------------------------------
   // Sender side. Offer words in bursts of random length; drop valid for a
   // random gap between bursts. Valid stays high across back-to-back words.
   // ---------------------------------------------------------------------
   task automatic push_word(input logic signed [SAMPLE_W-1:0] s, input bit typed,
                            input logic signed [SAMPLE_W-1:0] want);
      int           base;
      mix_word_type w;
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(0, 7) == 0 ? $urandom_range(10, 20)
                                           : $urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      req_bus.valid  <= 1'b1;
      req_bus.sample <= s;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // accepted at this edge: advance the behavioral copy
      base = pending_mix.size();
      fold_sample(s);
      if (typed) begin
         // replace the computed word with the hand-typed one
         while (pending_mix.size() > base) void'(pending_mix.pop_back());
         w.out_sample    = want;
         w.out_channel   = '0;
         w.last_of_frame = 1'b1;
         pending_mix.push_back(w);
      end
   endtask

   // Write one register once the block has gone quiet: every predicted word
   // received, then enough cycles for a word that closes no frame to settle.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [REG_W-1:0] val);
      req_bus.valid <= 1'b0;
      while (pending_mix.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      case (idx)
         CSR_IN_CHANNELS:  cfg_in_ch  = val;
         CSR_OUT_CHANNELS: cfg_out_ch = val;
         CSR_NORMALIZE:    cfg_norm   = val[0];
         default: ;
      endcase
   endtask

   function automatic logic signed [SAMPLE_W-1:0] draw_sample(input tone_type tone,
                                                              input bit neg);
      int                         mag;
      logic signed [SAMPLE_W-1:0] s;
      if ($urandom_range(0, 9) == 0) begin
         // sprinkle the field extremes into every phase
         case ($urandom_range(0, 3))
            0:       s = SAMPLE_MAX;
            1:       s = SAMPLE_MIN;
            2:       s = '0;
            default: s = '1;
         endcase
      end else begin
         case (tone)
            TONE_QUIET: s = SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
            TONE_LOUD: begin
               // same-sign large samples push the sums into the clip
               mag = $urandom_range(32'h400000, 32'h7FFFFF);
               s   = SAMPLE_W'(neg ? -mag : mag);
            end
            default:    s = SAMPLE_W'($urandom);
         endcase
      end
      return s;
   endfunction

   function automatic plan_row_type reg_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [REG_W-1:0] v);
      plan_row_type r;
      r.kind  = ROW_CSR;
      r.index = idx;
      r.value = SAMPLE_W'(v);
      r.typed = 1'b0;
      r.want  = '0;
      return r;
   endfunction

   function automatic plan_row_type word_row(input logic signed [SAMPLE_W-1:0] s);
      plan_row_type r;
      r.kind  = ROW_WORD;
      r.index = '0;
      r.value = s;
      r.typed = 1'b0;
      r.want  = '0;
      return r;
   endfunction

   function automatic plan_row_type typed_row(input logic signed [SAMPLE_W-1:0] s,
                                              input logic signed [SAMPLE_W-1:0] want);
      plan_row_type r;
      r       = word_row(s);
      r.typed = 1'b1;
      r.want  = want;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Clock, cycle count and watchdog
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("channel_fold_mixer verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Receiver side. Hold ready on a pattern of its own: runs of free flow,
   // choppy acceptance and slow acceptance. On request, hold off entirely
   // for a long stretch so the block backs up and stalls its input.
   // ---------------------------------------------------------------------
   initial begin
      drain_mode_type mode;
      int             run_left;
      mode     = DRAIN_FREE;
      run_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req && !reset) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end
         if (run_left == 0) begin
            mode     = drain_mode_type'($urandom_range(0, 2));
            run_left = $urandom_range(8, 64);
         end
         run_left--;
         case (mode)
            DRAIN_FREE:   rsp_bus.ready <= 1'b1;
            DRAIN_CHOPPY: rsp_bus.ready <= ($urandom_range(0, 1) == 1);
            default:      rsp_bus.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Checker: match every accepted word against the oldest prediction.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_mix.size() == 0) begin
            note_failure($sformatf("unexpected word: ch %0d sample %0d last %0b",
                                   rsp_bus.out_channel, rsp_bus.out_sample,
                                   rsp_bus.last_of_frame));
         end else begin
            head_word = pending_mix.pop_front();
            if (rsp_bus.out_sample !== head_word.out_sample ||
                rsp_bus.out_channel !== head_word.out_channel ||
                rsp_bus.last_of_frame !== head_word.last_of_frame) begin
               note_failure($sformatf(
                  "word mismatch: want ch %0d sample %0d last %0b, got ch %0d sample %0d last %0b",
                  head_word.out_channel, head_word.out_sample, head_word.last_of_frame,
                  rsp_bus.out_channel, rsp_bus.out_sample, rsp_bus.last_of_frame));
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus: directed plan, then random phases of whole frames
   // ---------------------------------------------------------------------
   initial begin
      int               words_done;
      int               span;
      int               frames;
      int               count;
      int               phase;
      logic [REG_W-1:0] in_raw;
      logic [REG_W-1:0] out_raw;
      logic             norm;
      tone_type         tone;
      bit               neg;

      // hold every input at a known value from time zero
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.sample <= '0;
      csr_bus.valid  <= 1'b0;
      csr_bus.index  <= '0;
      csr_bus.data   <= '0;
      fail_count   = 0;
      burst_left   = 0;
      hold_off_req = 1'b0;
      cfg_in_ch    = REG_W'(1);
      cfg_out_ch   = REG_W'(1);
      cfg_norm     = 1'b0;
      frame_pos    = 0;
      foreach (fold_sum[i]) fold_sum[i] = 0;

      // Directed plan. At reset both counts are one and the gain is unity,
      // so each word comes straight back on channel zero.
      plan.push_back(reg_row(CSR_UNUSED, 5'h1F));          // unknown index: no effect
      plan.push_back(typed_row(24'sd0, 24'sd0));
      plan.push_back(typed_row(SAMPLE_MAX, SAMPLE_MAX));
      plan.push_back(typed_row(SAMPLE_MIN, SAMPLE_MIN));
      plan.push_back(typed_row(-24'sd1, -24'sd1));
      // three inputs into one output, divided by three
      plan.push_back(reg_row(CSR_IN_CHANNELS, 5'd3));
      plan.push_back(reg_row(CSR_NORMALIZE, 5'd1));
      plan.push_back(word_row(SAMPLE_MAX));
      plan.push_back(word_row(SAMPLE_MAX));
      plan.push_back(typed_row(SAMPLE_MAX, SAMPLE_MAX));
      // -7 / 3 truncates toward zero
      plan.push_back(word_row(-24'sd2));
      plan.push_back(word_row(-24'sd2));
      plan.push_back(typed_row(-24'sd3, -24'sd2));
      // unity gain: sums clip at both rails
      plan.push_back(reg_row(CSR_NORMALIZE, 5'd0));
      plan.push_back(word_row(SAMPLE_MAX));
      plan.push_back(word_row(SAMPLE_MAX));
      plan.push_back(typed_row(24'sd1, SAMPLE_MAX));
      plan.push_back(word_row(SAMPLE_MIN));
      plan.push_back(word_row(-24'sd1));
      plan.push_back(typed_row(SAMPLE_MIN, SAMPLE_MIN));
      // counts out of range: zero acts as one, 31 acts as sixteen;
      // one input feeds channel zero, fifteen channels come out zero
      plan.push_back(reg_row(CSR_IN_CHANNELS, 5'd0));
      plan.push_back(reg_row(CSR_OUT_CHANNELS, 5'd31));
      plan.push_back(word_row(24'sh5A5A5A));
      // five into two with scaling by three, mixed signs
      plan.push_back(reg_row(CSR_IN_CHANNELS, 5'd5));
      plan.push_back(reg_row(CSR_OUT_CHANNELS, 5'd2));
      plan.push_back(reg_row(CSR_NORMALIZE, 5'd1));
      plan.push_back(word_row(-24'sd4));
      plan.push_back(word_row(24'sd7));
      plan.push_back(word_row(-24'sd1));
      plan.push_back(word_row(24'sd0));
      plan.push_back(word_row(-24'sd8));
      // output count changed in mid-frame: the frame carries on and folds
      // its later words with the new count
      plan.push_back(reg_row(CSR_IN_CHANNELS, 5'd4));
      plan.push_back(reg_row(CSR_OUT_CHANNELS, 5'd4));
      plan.push_back(reg_row(CSR_NORMALIZE, 5'd0));
      plan.push_back(word_row(24'sd100));
      plan.push_back(word_row(24'sd200));
      plan.push_back(reg_row(CSR_OUT_CHANNELS, 5'd2));
      plan.push_back(word_row(24'sd300));
      plan.push_back(word_row(24'sd400));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            csr_write(plan[i].index, plan[i].value[REG_W-1:0]);
         end else begin
            push_word(plan[i].value, plan[i].typed, plan[i].want);
         end
      end

      // Random phases. The first few pin the extremes of the counts and the
      // gain; phase 2 also holds off the receiver to back up the block.
      words_done = 0;
      for (phase = 0; words_done < RANDOM_WORDS; phase++) begin
         norm = 1'b0;
         case (phase)
            0: begin in_raw = 5'd16; out_raw = 5'd16; norm = 1'b1; end
            1: begin in_raw = 5'd16; out_raw = 5'd1;  norm = 1'b0; end
            2: begin in_raw = 5'd4;  out_raw = 5'd4;  norm = 1'b0; end
            3: begin in_raw = 5'd1;  out_raw = 5'd16; norm = 1'b1; end
            4: begin in_raw = 5'd0;  out_raw = 5'd31; norm = 1'b1; end
            5: begin in_raw = 5'd31; out_raw = 5'd0;  norm = 1'b1; end
            6: begin in_raw = 5'd16; out_raw = 5'd1;  norm = 1'b1; end
            default: begin
               in_raw  = ($urandom_range(0, 7) == 0) ? REG_W'($urandom_range(0, 31))
                                                     : REG_W'($urandom_range(1, 16));
               out_raw = ($urandom_range(0, 7) == 0) ? REG_W'($urandom_range(0, 31))
                                                     : REG_W'($urandom_range(1, 16));
               norm    = $urandom_range(0, 1);
            end
         endcase
         csr_write(CSR_IN_CHANNELS, in_raw);
         csr_write(CSR_OUT_CHANNELS, out_raw);
         // upper bits of the gain register carry noise; only bit zero counts
         csr_write(CSR_NORMALIZE, {REG_W'($urandom)} & ~REG_W'(1) | REG_W'(norm));
         if ($urandom_range(0, 4) == 0) begin
            csr_write(CSR_UNUSED, REG_W'($urandom));
         end

         span   = span_of(in_raw);
         frames = (span >= 12) ? $urandom_range(1, 2) : $urandom_range(1, 4);
         count  = frames * span;
         if (phase == 2) begin
            count = 6 * span;
         end else if (span > 1 && $urandom_range(0, 5) == 0) begin
            // leave a frame open across the next register writes
            count += $urandom_range(1, span - 1);
         end
         case ($urandom_range(0, 3))
            0:       tone = TONE_QUIET;
            1:       tone = TONE_LOUD;
            default: tone = TONE_FULL;
         endcase
         neg = $urandom_range(0, 1);

         if (phase == 2) hold_off_req = 1'b1;
         repeat (count) push_word(draw_sample(tone, neg), 1'b0, '0);
         words_done += count;
      end

      // drain: wait for every predicted word, then a quiet tail
      req_bus.valid <= 1'b0;
      while (pending_mix.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_mix.size() != 0) begin
         note_failure($sformatf("%0d predicted words never arrived", pending_mix.size()));
      end

      if (fail_count == 0) begin
         $display("channel_fold_mixer verification clean");
      end else begin
         $display("channel_fold_mixer verification failed");
      end
      $finish;
   end

endmodule
